// ===== sv/mtsq_pkg.sv =====
// Package for the MIDI transport step quantizer.
// Holds the shared sizes, MIDI byte codes, enums and structs.
// No dependencies; every other file of the block imports it.
package mtsq_pkg;

   // Longest step cycle that the step counter supports.
   localparam int MAX_STEPS = 64;
   // Width of the step index.
   localparam int STEP_W = $clog2(MAX_STEPS);
   // Width that holds the cycle length itself.
   localparam int LEN_W = $clog2(MAX_STEPS + 1);
   // Width of the steps_per_cycle register.
   localparam int SPC_W = 7;
   // Common width for the cycle-length compare.
   localparam int CMP_W = (LEN_W > SPC_W) ? LEN_W : SPC_W;

   // MIDI realtime bytes.
   localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
   localparam logic [7:0] MIDI_START    = 8'hFA;
   localparam logic [7:0] MIDI_CONTINUE = 8'hFB;
   localparam logic [7:0] MIDI_STOP     = 8'hFC;

   // Reset values of the configuration registers.
   localparam logic [7:0]       TPS_RESET  = 8'd6;
   localparam logic [SPC_W-1:0] SPC_RESET  = 7'd16;
   localparam logic [1:0]       HOLD_RESET = 2'd0;
   localparam logic             PASS_RESET = 1'b1;

   // Hold modes.
   localparam logic [1:0] HOLD_NONE       = 2'd0;
   localparam logic [1:0] HOLD_START_STOP = 2'd2;

   // Transport states.
   typedef enum logic [1:0] {
      ST_STOPPED    = 2'd0,
      ST_PEND_START = 2'd1,
      ST_STARTED    = 2'd2,
      ST_PEND_STOP  = 2'd3
   } transport_type;

   // Request functions.
   typedef enum logic [2:0] {
      FN_BUTTON   = 3'd0,
      FN_TICK     = 3'd1,
      FN_START    = 3'd2,
      FN_CONTINUE = 3'd3,
      FN_STOP     = 3'd4,
      FN_OTHER    = 3'd5
   } func_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_TICKS_PER_STEP  = 2'd0,
      CSR_STEPS_PER_CYCLE = 2'd1,
      CSR_HOLD_MODE       = 2'd2,
      CSR_PASS_THROUGH    = 2'd3
   } csr_index_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [7:0]       ticks_per_step;
      logic [SPC_W-1:0] steps_per_cycle;
      logic [1:0]       hold_sel;
      logic             pass_through;
   } cfg_type;

   // Everything one request produces: up to two bytes plus the status after it.
   typedef struct packed {
      logic              first_valid;
      logic [7:0]        first_byte;
      logic              step_pulse;
      logic              cycle_pulse;
      logic              extra_valid;
      logic [7:0]        extra_byte;
      logic [1:0]        transport;
      logic [STEP_W-1:0] step_index;
      logic              first_half;
   } rec_type;

endpackage

// ===== sv/midi_transport_step_quantizer_top.sv =====
// MIDI transport step quantizer: per hold mode, holds start/stop until a step cycle ends.
// A request waits in the input register, then in the result queue, whose head drives
// the result port. Throughput: one request per cycle while the queue has room; a tick
// that also releases a held start or stop gives two results, one after the other.
// Reset clears the transport, counters and result queue and restores the
// configuration registers to their defaults. Depends on mtsq_pkg and submodules.
module midi_transport_step_quantizer_top import mtsq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_func,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_byte_valid,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_step_pulse,
   output logic              rsp_cycle_pulse,
   output logic [1:0]        rsp_transport_state,
   output logic [STEP_W-1:0] rsp_step_index,
   output logic              rsp_half_step,
   output logic              rsp_last
);

   cfg_type cfg;
   logic    queue_full;
   logic    push;
   rec_type push_rec;

   // Configuration registers.
   mtsq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Transport state machine and counters.
   mtsq_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_rec      (push_rec)
   );

   // Result queue and output sequencing.
   mtsq_out_queue u_out_queue (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .push_rec            (push_rec),
      .queue_full          (queue_full),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_step_pulse      (rsp_step_pulse),
      .rsp_cycle_pulse     (rsp_cycle_pulse),
      .rsp_transport_state (rsp_transport_state),
      .rsp_step_index      (rsp_step_index),
      .rsp_half_step       (rsp_half_step),
      .rsp_last            (rsp_last)
   );

endmodule

// ===== sv/mtsq_csr.sv =====
// Configuration registers of the MIDI transport step quantizer.
// Depends on mtsq_pkg for the register indexes, reset values and cfg_type.
module mtsq_csr import mtsq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_wdata,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   // The register file is always ready for a write transaction.
   assign csr_ready = 1'b1;
   assign write_en  = csr_valid & csr_ready;

   // Decode the write into the register file.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_index_type'(csr_index))
            CSR_TICKS_PER_STEP:  cfg_in.ticks_per_step  = csr_wdata;
            CSR_STEPS_PER_CYCLE: cfg_in.steps_per_cycle = csr_wdata[SPC_W-1:0];
            CSR_HOLD_MODE:       cfg_in.hold_sel        = csr_wdata[1:0];
            CSR_PASS_THROUGH:    cfg_in.pass_through    = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // Register file with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_step  <= TPS_RESET;
         cfg_ff.steps_per_cycle <= SPC_RESET;
         cfg_ff.hold_sel        <= HOLD_RESET;
         cfg_ff.pass_through    <= PASS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/mtsq_core.sv =====
// Input register, transport state and counters of the step quantizer.
// Depends on mtsq_pkg; produces one rec_type per request for the result queue.
module mtsq_core import mtsq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic [2:0] req_func,
   input  logic [7:0] req_data_byte,
   input  logic     queue_full,
   output logic     push,
   output rec_type  push_rec
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [2:0] in_func_ff;
   logic [7:0] in_byte_ff;

   // Transport state and counters.
   transport_type     transport_ff, transport_in;
   logic [7:0]        tick_ff, tick_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              half_ff, half_in;
   logic              toggle_ff, toggle_in;

   logic              req_accept;
   logic [7:0]        tick_plus;
   logic              step_done;
   logic [CMP_W-1:0]  step_plus;
   logic [CMP_W-1:0]  spc_ext;
   logic [CMP_W-1:0]  cycle_len;
   logic              cycle_done;
   logic [7:0]        tick_next;
   logic              step_nonzero;

   // The held transaction moves on whenever the result queue has room.
   assign push       = in_valid_ff & ~queue_full;
   assign req_stall  = in_valid_ff & queue_full;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (push) begin
         in_valid_in = 1'b0;
      end
   end

   // Tick prescaler and step counter arithmetic.
   assign tick_plus    = tick_ff + 8'd1;
   assign step_done    = (tick_plus >= cfg.ticks_per_step);
   assign tick_next    = step_done ? 8'd0 : tick_plus;
   assign step_plus    = CMP_W'(step_ff) + CMP_W'(1);
   assign spc_ext      = CMP_W'(cfg.steps_per_cycle);
   assign cycle_len    = (spc_ext > CMP_W'(MAX_STEPS)) ? CMP_W'(MAX_STEPS) : spc_ext;
   assign cycle_done   = step_done & (step_plus >= cycle_len);
   assign step_nonzero = (step_ff != '0);

   // Next state and result record of the held request.
   always_comb begin
      transport_in = transport_ff;
      tick_in      = tick_ff;
      step_in      = step_ff;
      half_in      = half_ff;
      toggle_in    = toggle_ff;
      push_rec     = '0;

      case (func_type'(in_func_ff))
         FN_BUTTON: begin
            case (transport_ff)
               ST_STARTED: begin
                  if (cfg.hold_sel == HOLD_START_STOP && step_nonzero) begin
                     transport_in = ST_PEND_STOP;
                  end else begin
                     push_rec.first_valid = 1'b1;
                     push_rec.first_byte  = MIDI_STOP;
                     transport_in         = ST_STOPPED;
                  end
               end
               ST_STOPPED: begin
                  if (cfg.hold_sel != HOLD_NONE && step_nonzero) begin
                     transport_in = ST_PEND_START;
                  end else begin
                     push_rec.first_valid = 1'b1;
                     push_rec.first_byte  = MIDI_START;
                     transport_in         = ST_STARTED;
                     tick_in              = 8'd0;
                     step_in              = '0;
                  end
               end
               ST_PEND_START: transport_in = ST_STOPPED;
               default:       transport_in = ST_STARTED;
            endcase
         end
         FN_TICK: begin
            push_rec.first_valid = 1'b1;
            push_rec.first_byte  = MIDI_CLOCK;
            push_rec.step_pulse  = step_done;
            push_rec.cycle_pulse = cycle_done;
            tick_in              = tick_next;
            if (cycle_done) begin
               step_in = '0;
               if (transport_ff == ST_PEND_START) begin
                  push_rec.extra_valid = 1'b1;
                  push_rec.extra_byte  = MIDI_START;
                  transport_in         = ST_STARTED;
               end else if (transport_ff == ST_PEND_STOP) begin
                  push_rec.extra_valid = 1'b1;
                  push_rec.extra_byte  = MIDI_STOP;
                  transport_in         = ST_STOPPED;
               end
            end else if (step_done) begin
               step_in = step_plus[STEP_W-1:0];
            end
            // Short steps toggle the flag; longer ones compare against half a step.
            if (cfg.ticks_per_step < 8'd4) begin
               toggle_in = ~toggle_ff;
               half_in   = ~toggle_ff;
            end else begin
               half_in = (tick_next < (cfg.ticks_per_step >> 1));
            end
         end
         FN_START: begin
            push_rec.first_valid = 1'b1;
            push_rec.first_byte  = MIDI_START;
            tick_in              = 8'd0;
            step_in              = '0;
            transport_in         = ST_STARTED;
         end
         FN_CONTINUE: begin
            push_rec.first_valid = 1'b1;
            push_rec.first_byte  = MIDI_CONTINUE;
            transport_in         = ST_STARTED;
         end
         FN_STOP: begin
            push_rec.first_valid = 1'b1;
            push_rec.first_byte  = MIDI_STOP;
            tick_in              = 8'd0;
            step_in              = '0;
            transport_in         = ST_STOPPED;
         end
         FN_OTHER: begin
            if (cfg.pass_through) begin
               push_rec.first_valid = 1'b1;
               push_rec.first_byte  = in_byte_ff;
            end
         end
         default: begin
            push_rec.first_valid = 1'b0;
         end
      endcase

      push_rec.transport  = transport_in;
      push_rec.step_index = step_in;
      push_rec.first_half = half_in;
   end

   // Input register: control is reset, payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_data_byte;
      end
   end

   // Transport state and counters update when the request leaves for the queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         transport_ff <= ST_STOPPED;
         tick_ff      <= 8'd0;
         step_ff      <= '0;
         half_ff      <= 1'b0;
         toggle_ff    <= 1'b0;
      end else if (push) begin
         transport_ff <= transport_in;
         tick_ff      <= tick_in;
         step_ff      <= step_in;
         half_ff      <= half_in;
         toggle_ff    <= toggle_in;
      end
   end

endmodule

// ===== sv/mtsq_out_queue.sv =====
// Two-entry result queue of the step quantizer; splits a record into its results.
// Depends on mtsq_pkg for rec_type and STEP_W.
module mtsq_out_queue import mtsq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rec_type           push_rec,
   output logic              queue_full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_byte_valid,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_step_pulse,
   output logic              rsp_cycle_pulse,
   output logic [1:0]        rsp_transport_state,
   output logic [STEP_W-1:0] rsp_step_index,
   output logic              rsp_half_step,
   output logic              rsp_last
);

   rec_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       second_ff, second_in;
   rec_type    head;
   logic       rsp_accept;
   logic       pop;

   assign queue_full = (count_ff == 2'd2);
   assign rsp_valid  = (count_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];
   assign rsp_accept = rsp_valid & ~rsp_stall;

   // A record with an extra byte takes two result transactions.
   assign pop = rsp_accept & (second_ff | ~head.extra_valid);

   always_comb begin
      rsp_transport_state = head.transport;
      rsp_step_index      = head.step_index;
      rsp_half_step       = head.first_half;
      if (second_ff) begin
         rsp_byte_valid  = 1'b1;
         rsp_out_byte    = head.extra_byte;
         rsp_step_pulse  = 1'b0;
         rsp_cycle_pulse = 1'b0;
         rsp_last        = 1'b1;
      end else begin
         rsp_byte_valid  = head.first_valid;
         rsp_out_byte    = head.first_byte;
         rsp_step_pulse  = head.step_pulse;
         rsp_cycle_pulse = head.cycle_pulse;
         rsp_last        = ~head.extra_valid;
      end
   end

   // Pointer, count and phase bookkeeping.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
      second_in = second_ff;
      if (pop) begin
         second_in = 1'b0;
      end else if (rsp_accept) begin
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         second_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         second_ff <= second_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule
